### design/bftm_pkg.sv
// Package for the brute-force tour minimum block: field widths, micro-op codes
// and the sequencer program ROM. No dependencies.
package bftm_pkg;

    localparam int IDX_W    = 2;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 18;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam int PC_W     = 4;
    localparam int PROG_LEN = 11;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_INIT,
        OP_TOUR,
        OP_ISSUE,
        OP_ACCUM,
        OP_KEEP,
        OP_PIVOT,
        OP_SWAP,
        OP_REVERSE,
        OP_EMIT,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        F_NONE,
        F_ALWAYS,
        F_NOT_START,
        F_MORE_EDGES,
        F_NO_PIVOT,
        F_OUT_BUSY
    } t_flag;

    typedef struct packed {
        t_op             op;
        t_flag           cond;
        logic [PC_W-1:0] target;
    } t_uop;

    localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] PC_INIT    = 4'd1;
    localparam logic [PC_W-1:0] PC_TOUR    = 4'd2;
    localparam logic [PC_W-1:0] PC_ISSUE   = 4'd3;
    localparam logic [PC_W-1:0] PC_ACCUM   = 4'd4;
    localparam logic [PC_W-1:0] PC_KEEP    = 4'd5;
    localparam logic [PC_W-1:0] PC_PIVOT   = 4'd6;
    localparam logic [PC_W-1:0] PC_SWAP    = 4'd7;
    localparam logic [PC_W-1:0] PC_REVERSE = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT    = 4'd9;
    localparam logic [PC_W-1:0] PC_RETURN  = 4'd10;

    // jump to target when the selected flag is true, else advance
    localparam t_uop PROG [PROG_LEN] = '{
        '{OP_IDLE,    F_NOT_START,  PC_IDLE},
        '{OP_INIT,    F_NONE,       PC_IDLE},
        '{OP_TOUR,    F_NONE,       PC_IDLE},
        '{OP_ISSUE,   F_NONE,       PC_IDLE},
        '{OP_ACCUM,   F_MORE_EDGES, PC_ISSUE},
        '{OP_KEEP,    F_NONE,       PC_IDLE},
        '{OP_PIVOT,   F_NO_PIVOT,   PC_EMIT},
        '{OP_SWAP,    F_NONE,       PC_IDLE},
        '{OP_REVERSE, F_ALWAYS,     PC_TOUR},
        '{OP_EMIT,    F_OUT_BUSY,   PC_EMIT},
        '{OP_NOP,     F_ALWAYS,     PC_IDLE}
    };

endpackage

### design/bftm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bftm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/brute_force_tour_minimum.sv
// Brute-force tour minimum: matrix entries load at one transfer per cycle while idle.
// The transfer marked last starts a microcoded search; the minimum is offered once
// every tour is summed, each edge fetched from the single-read weight RAM, and after
// any wait for an older result to be taken. Loads are refused until the sequencer is
// back in its idle step, past a no-op step after the offer. Synchronous active-low
// reset clears sequencer, start vertex, best sum, output valid. Uses bftm_pkg, bftm_ram.
module brute_force_tour_minimum #(
    parameter int NUM_VERTICES = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bftm_pkg::IDX_W-1:0]    i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bftm_pkg::IDX_W-1:0]    i_row_index,
    input  logic [bftm_pkg::IDX_W-1:0]    i_col_index,
    input  logic [bftm_pkg::WEIGHT_W-1:0] i_edge_weight,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bftm_pkg::SUM_W-1:0]    o_min_weight
);

    localparam int VW      = $clog2(NUM_VERTICES);
    localparam int ORD_LEN = NUM_VERTICES - 1;
    localparam int OW      = $clog2(ORD_LEN);
    localparam int DEPTH   = NUM_VERTICES * NUM_VERTICES;
    localparam int AW      = $clog2(DEPTH);

    logic [bftm_pkg::PC_W-1:0]     r_pc;
    logic [bftm_pkg::PC_W-1:0]     n_pc;
    bftm_pkg::t_uop                uop;
    logic [bftm_pkg::IDX_W-1:0]    r_start;
    logic [VW-1:0]                 r_order [ORD_LEN];
    logic [bftm_pkg::SUM_W-1:0]    r_sum;
    logic [bftm_pkg::SUM_W-1:0]    r_best;
    logic [VW-1:0]                 r_cur;
    logic [VW-1:0]                 r_idx;
    logic [VW-1:0]                 r_tgt;
    logic [OW-1:0]                 r_piv;
    logic                          r_out_valid;
    logic [bftm_pkg::SUM_W-1:0]    r_out;

    logic                          in_xfer;
    logic                          in_range;
    logic                          start_search;
    logic                          out_busy;
    logic                          jump;
    logic [VW-1:0]                 start_c;
    logic [VW-1:0]                 tgt_c;
    logic [OW-1:0]                 piv_c;
    logic                          piv_found;
    logic [OW-1:0]                 succ_c;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic [bftm_pkg::WEIGHT_W-1:0] rd_data;
    logic [bftm_pkg::SUM_W:0]      sum_wide;

    assign uop          = bftm_pkg::PROG[r_pc];
    assign o_stall      = (uop.op != bftm_pkg::OP_IDLE);
    assign in_xfer      = i_valid && !o_stall;
    assign in_range     = (int'(i_row_index) < NUM_VERTICES) &&
                          (int'(i_col_index) < NUM_VERTICES);
    assign start_search = in_xfer && i_last;
    assign out_busy     = r_out_valid && i_stall;
    assign start_c      = (int'(r_start) < NUM_VERTICES) ? VW'(r_start) : '0;
    assign tgt_c        = (int'(r_idx) == ORD_LEN) ? start_c : r_order[r_idx[OW-1:0]];
    assign wr_addr      = AW'(int'(i_row_index) * NUM_VERTICES + int'(i_col_index));
    assign rd_addr      = AW'(int'(r_cur) * NUM_VERTICES + int'(tgt_c));
    assign sum_wide     = {1'b0, r_sum} + (bftm_pkg::SUM_W + 1)'(rd_data);

    bftm_ram #(
        .WIDTH (bftm_pkg::WEIGHT_W),
        .DEPTH (DEPTH)
    ) u_weights (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && in_range),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_edge_weight),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        piv_found = 1'b0;
        piv_c     = '0;
        for (int j = 0; j < ORD_LEN - 1; j++) begin
            if (r_order[j] < r_order[j+1]) begin
                piv_found = 1'b1;
                piv_c     = OW'(j);
            end
        end
    end

    always_comb begin
        succ_c = r_piv;
        for (int j = 0; j < ORD_LEN; j++) begin
            if (j > int'(r_piv) && r_order[j] > r_order[r_piv]) begin
                succ_c = OW'(j);
            end
        end
    end

    always_comb begin
        unique case (uop.cond)
            bftm_pkg::F_NONE:       jump = 1'b0;
            bftm_pkg::F_ALWAYS:     jump = 1'b1;
            bftm_pkg::F_NOT_START:  jump = !start_search;
            bftm_pkg::F_MORE_EDGES: jump = (int'(r_idx) != ORD_LEN);
            bftm_pkg::F_NO_PIVOT:   jump = !piv_found;
            bftm_pkg::F_OUT_BUSY:   jump = out_busy;
            default:                jump = 1'b1;
        endcase
        n_pc = jump ? uop.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= bftm_pkg::PC_IDLE;
            r_start     <= '0;
            r_best      <= bftm_pkg::SUM_MAX;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_wr_en) begin
                r_start <= i_cfg_wr_data;
            end
            if (r_out_valid && !i_stall && uop.op != bftm_pkg::OP_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (uop.op)
                bftm_pkg::OP_INIT: begin
                    for (int k = 0; k < ORD_LEN; k++) begin
                        r_order[k] <= (k < int'(start_c)) ? VW'(k) : VW'(k + 1);
                    end
                    r_best <= bftm_pkg::SUM_MAX;
                end
                bftm_pkg::OP_TOUR: begin
                    r_sum <= '0;
                    r_cur <= start_c;
                    r_idx <= '0;
                end
                bftm_pkg::OP_ISSUE: begin
                    r_tgt <= tgt_c;
                end
                bftm_pkg::OP_ACCUM: begin
                    r_sum <= sum_wide[bftm_pkg::SUM_W] ? bftm_pkg::SUM_MAX
                                                       : sum_wide[bftm_pkg::SUM_W-1:0];
                    r_cur <= r_tgt;
                    r_idx <= r_idx + 1'b1;
                end
                bftm_pkg::OP_KEEP: begin
                    if (r_sum < r_best) begin
                        r_best <= r_sum;
                    end
                end
                bftm_pkg::OP_PIVOT: begin
                    r_piv <= piv_c;
                end
                bftm_pkg::OP_SWAP: begin
                    r_order[r_piv]  <= r_order[succ_c];
                    r_order[succ_c] <= r_order[r_piv];
                end
                bftm_pkg::OP_REVERSE: begin
                    for (int j = 0; j < ORD_LEN; j++) begin
                        if (j > int'(r_piv)) begin
                            r_order[j] <= r_order[OW'(int'(r_piv) + ORD_LEN - j)];
                        end
                    end
                end
                bftm_pkg::OP_EMIT: begin
                    if (!out_busy) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_best;
                    end
                end
                bftm_pkg::OP_IDLE, bftm_pkg::OP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_min_weight = r_out;

    a_start_enters_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_search |=> (r_pc == bftm_pkg::PC_INIT))
        else $error("search start did not enter init step");

    a_best_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop.op != bftm_pkg::OP_INIT) |=> (r_best <= $past(r_best)))
        else $error("best sum rose outside init step");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop.op == bftm_pkg::OP_EMIT && !out_busy)
            |=> (o_valid && o_min_weight == $past(r_best)))
        else $error("emit step did not present best sum");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uop.op == bftm_pkg::OP_ISSUE || uop.op == bftm_pkg::OP_ACCUM)
            |-> (int'(r_idx) <= ORD_LEN))
        else $error("edge index beyond tour length");

endmodule
